### rtl/core/tsgd_pkg.sv
// Package for the tachometer stepper gauge driver: widths, register codes, constants.
`timescale 1ns / 1ps
package tsgd_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int RATE_W      = 16;
	localparam int POS_W       = 10;
	localparam int DIFF_W      = (COUNT_WIDTH > 10) ? COUNT_WIDTH : 10;
	localparam int GAIN_W      = 16;
	localparam int PROD_W      = GAIN_W + DIFF_W;
	localparam int DIV_IN_W    = 20;
	localparam int QUO_MUL_W   = 21;
	localparam int QUO_SHIFT   = 30;
	localparam int QUO_W       = 11;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int WAIT_W      = 3;

	// floor(x / 1000) == (x * ceil(2^30 / 1000)) >> 30 for any 20-bit x
	localparam logic [QUO_MUL_W-1:0] QUO_MUL = 21'd1073742;

	// cycles from a rate or register change until the target register is current
	localparam logic [WAIT_W-1:0] TGT_LAT = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_RATE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN         = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_POSITION = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_STEP     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HOME_STEPS   = 3'd5;

	localparam logic [9:0]  MIN_RATE_RST     = 10'd30;
	localparam logic [15:0] GAIN_RST         = 16'd3306;
	localparam logic [9:0]  OFFSET_RST       = 10'd19;
	localparam logic [9:0]  MAX_POSITION_RST = 10'd600;
	localparam logic [7:0]  MIN_STEP_RST     = 8'd5;
	localparam logic [9:0]  HOME_STEPS_RST   = 10'd601;

	// full-step coil patterns: bit0 A+, bit1 A-, bit2 B+, bit3 B-
	function automatic logic [3:0] phase_of(input logic [1:0] idx);
		logic [3:0] p;
		case (idx)
			2'd0: p = 4'h5;
			2'd1: p = 4'h9;
			2'd2: p = 4'hA;
			2'd3: p = 4'h6;
			default: p = 4'h5;
		endcase
		return p;
	endfunction

endpackage

### rtl/core/tacho_stepper_gauge_driver_core.sv
// Top level of the tachometer stepper gauge driver: counting, target, stepping, output register.
`timescale 1ns / 1ps
// Every input transfer yields exactly one result transfer. Pulse edges are counted per
// measuring window and the count is latched as the rate at each window end. While no move
// runs, the target position comes from a four-stage target pipeline (subtract, multiply by
// gain, divide by 1000 through a reciprocal multiply, offset and clamp) fed by the latched
// rate and the registers. Items are taken one per cycle while the output can take a result
// and no item is held; an item that arrives while the needle is idle and either ends a window
// or follows a register write or window end before the target pipeline has caught up is held
// until the pipeline has caught up: its result is produced only then, and no input is taken
// while it is held. After reset a counter-clockwise homing run of 601 steps is pending; writes
// to home_steps are accepted and have no effect. The register port is always ready.
module tacho_stepper_gauge_driver_core
	import tsgd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [7:0]            s_axis_tdata,  // [0] pulse_edge, [1] window_end, [2] step_tick
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [31:0]           m_axis_tdata,  // [3:0] phases, [13:4] needle_position,
	                                             // [29:14] rate, [30] moving
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// registers
	logic [9:0]  min_rate_q;
	logic [15:0] gain_q;
	logic [9:0]  offset_q;
	logic [9:0]  max_position_q;
	logic [7:0]  min_step_q;

	// state
	logic [COUNT_WIDTH-1:0] pulse_count_q, latched_rate_q;
	logic [POS_W-1:0]       position_q, steps_left_q;
	logic [1:0]             seq_index_q;
	logic                   turn_ccw_q;
	logic [3:0]             phase_out_q;
	logic                   pend_q;
	logic [WAIT_W-1:0]      tgt_wait_q;

	// target pipeline
	logic                   below_s1, below_s2, below_s3;
	logic [DIFF_W-1:0]      diff_s1;
	logic [PROD_W-1:0]      prod_s2;
	logic                   big_s3;
	logic [QUO_W-1:0]       quo_s3;
	logic [POS_W-1:0]       tgt_s4;

	logic                   out_valid_q;
	logic [31:0]            out_data_q;

	logic                   in_acc, cfg_acc, out_free;
	logic                   edge_in, wend_in, tick_in;
	logic                   idle, eval_now, pend_set, pend_done, do_eval, do_tick, produce;
	logic [COUNT_WIDTH-1:0] pulse_n, latched_n;
	logic [POS_W-1:0]       position_n, steps_left_n, move_dist;
	logic [1:0]             seq_n;
	logic                   ccw_n;
	logic [3:0]             phase_n;
	logic [RATE_W-1:0]      rate_sat;
	logic [DIFF_W-1:0]      rate_x, min_x;
	logic [DIV_IN_W+QUO_MUL_W-1:0] quo_prod;
	logic [QUO_W:0]         tgt_sum;

	assign edge_in = s_axis_tdata[0];
	assign wend_in = s_axis_tdata[1];
	assign tick_in = s_axis_tdata[2];

	assign out_free      = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !pend_q && out_free;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;
	assign cfg_acc       = cfg_valid && cfg_ready;

	assign idle      = (steps_left_q == '0);
	assign eval_now  = in_acc && idle && !wend_in && (tgt_wait_q == '0);
	assign pend_set  = in_acc && idle && !eval_now;
	assign pend_done = pend_q && (tgt_wait_q == '0) && out_free;
	assign do_eval   = eval_now || pend_done;
	assign do_tick   = in_acc && !idle && tick_in;
	assign produce   = (in_acc && !pend_set) || pend_done;

	// pulse counting and rate latch
	always_comb begin
		pulse_n   = pulse_count_q;
		latched_n = latched_rate_q;
		if (in_acc) begin
			if (wend_in) begin
				latched_n = pulse_count_q;
				pulse_n   = COUNT_WIDTH'(edge_in);
			end else if (edge_in && (pulse_count_q != {COUNT_WIDTH{1'b1}})) begin
				pulse_n = pulse_count_q + 1'b1;
			end
		end
	end

	generate
		if (COUNT_WIDTH > RATE_W) begin : g_rate_sat
			assign rate_sat = (|latched_n[COUNT_WIDTH-1:RATE_W]) ? {RATE_W{1'b1}}
			                                                      : latched_n[RATE_W-1:0];
		end else begin : g_rate_ext
			assign rate_sat = RATE_W'(latched_n);
		end
	endgenerate

	// stepping and move start
	assign move_dist = (tgt_s4 > position_q) ? (tgt_s4 - position_q) : (position_q - tgt_s4);

	always_comb begin
		position_n   = position_q;
		steps_left_n = steps_left_q;
		seq_n        = seq_index_q;
		ccw_n        = turn_ccw_q;
		phase_n      = phase_out_q;
		if (do_tick) begin
			phase_n      = phase_of(seq_index_q);
			seq_n        = seq_index_q + (turn_ccw_q ? 2'd3 : 2'd1);
			steps_left_n = steps_left_q - 1'b1;
		end else if (do_eval && (move_dist > {2'b00, min_step_q})) begin
			ccw_n        = (tgt_s4 < position_q);
			steps_left_n = move_dist;
			position_n   = tgt_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_rate_q     <= MIN_RATE_RST;
			gain_q         <= GAIN_RST;
			offset_q       <= OFFSET_RST;
			max_position_q <= MAX_POSITION_RST;
			min_step_q     <= MIN_STEP_RST;
		end else if (cfg_acc) begin
			case (cfg_index)
				REG_MIN_RATE:     min_rate_q     <= cfg_data[9:0];
				REG_GAIN:         gain_q         <= cfg_data;
				REG_OFFSET:       offset_q       <= cfg_data[9:0];
				REG_MAX_POSITION: max_position_q <= cfg_data[9:0];
				REG_MIN_STEP:     min_step_q     <= cfg_data[7:0];
				REG_HOME_STEPS:   ;
				default:          ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_count_q  <= '0;
			latched_rate_q <= '0;
			position_q     <= '0;
			steps_left_q   <= HOME_STEPS_RST;
			seq_index_q    <= '0;
			turn_ccw_q     <= 1'b1;
			phase_out_q    <= '0;
			pend_q         <= 1'b0;
			tgt_wait_q     <= TGT_LAT;
			out_valid_q    <= 1'b0;
		end else begin
			pulse_count_q  <= pulse_n;
			latched_rate_q <= latched_n;
			position_q     <= position_n;
			steps_left_q   <= steps_left_n;
			seq_index_q    <= seq_n;
			turn_ccw_q     <= ccw_n;
			phase_out_q    <= phase_n;
			if (pend_set)
				pend_q <= 1'b1;
			else if (pend_done)
				pend_q <= 1'b0;
			if (cfg_acc || (in_acc && wend_in))
				tgt_wait_q <= TGT_LAT;
			else if (tgt_wait_q != '0)
				tgt_wait_q <= tgt_wait_q - 1'b1;
			if (produce)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (produce)
			out_data_q <= {1'b0, (steps_left_n != '0), rate_sat, position_n, phase_n};
	end

	// target pipeline: stage 1 subtract, stage 2 gain product, stage 3 divide, stage 4 clamp
	assign rate_x   = DIFF_W'(latched_rate_q);
	assign min_x    = DIFF_W'(min_rate_q);
	assign quo_prod = prod_s2[DIV_IN_W-1:0] * QUO_MUL;
	assign tgt_sum  = {1'b0, quo_s3} + (QUO_W+1)'(offset_q);

	always_ff @(posedge clk) begin
		below_s1 <= (rate_x < min_x);
		diff_s1  <= rate_x - min_x;
		below_s2 <= below_s1;
		prod_s2  <= gain_q * diff_s1;
		below_s3 <= below_s2;
		big_s3   <= |prod_s2[PROD_W-1:DIV_IN_W];
		quo_s3   <= quo_prod[QUO_SHIFT+QUO_W-1:QUO_SHIFT];
		if (below_s3)
			tgt_s4 <= '0;
		else if (big_s3 || (tgt_sum > (QUO_W+1)'(max_position_q)))
			tgt_s4 <= max_position_q;
		else
			tgt_s4 <= tgt_sum[POS_W-1:0];
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	a_pend_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> !s_axis_tready)
		else $error("input taken while an evaluation is pending");

	a_idle_keeps_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && idle) |=> $stable(phase_out_q))
		else $error("coil pattern changed on an idle item");

	a_move_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(position_q) |-> ($past(steps_left_q) == '0))
		else $error("needle position changed during a move");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !idle) |=> m_axis_tvalid)
		else $error("stepping item gave no result");

endmodule
